### src/cbd_pkg.sv
package cbd_pkg;

  // Defaults for the top-level parameters
  localparam int SIZE_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // One hex digit carries this many bits of the chunk size (radix 16)
  localparam int HEX_DIGIT_BITS = 4;

  typedef enum logic [1:0] {
    STATUS_BUSY  = 2'd0,
    STATUS_DONE  = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  // Classified input word, front to back
  typedef struct packed {
    logic [7:0] raw;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
  } class_t;

  // Result word, back to output queue
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       chunk_last_byte;
    status_t    status;
  } result_t;

endpackage

### src/http_chunked_body_decoder_top.sv
// Channel | Ports                                   | Dir | Accepted when
// input   | in_push, in_byte, in_full               | in  | in_push && !in_full
// result  | out_pop, out_empty, out_data_valid,     | out | out_pop && !out_empty
//         | out_data_byte, out_chunk_last_byte,     |     |
//         | out_status                              |     |
//
// One word in, one result word out, one per cycle while results are popped;
// the parser's size/phase update adds no register, so the queues alone hold a
// byte on its way: it is written into the classified queue, then into the
// result queue, from which it can be popped.
// rst_n is synchronous, active low, and clears phase, size count and queues.
// A stalled result side fills the output queue, then the input queue, and
// only then raises in_full; the front and back stall independently.
module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS   = cbd_pkg::SIZE_BITS_DEF,   // 8..63
  parameter int QUEUE_DEPTH = cbd_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_byte,
  output logic       in_full,
  input  logic       out_pop,
  output logic       out_empty,
  output logic       out_data_valid,
  output logic [7:0] out_data_byte,
  output logic       out_chunk_last_byte,
  output logic [1:0] out_status
);

  localparam int CW = $bits(cbd_pkg::class_t);
  localparam int RW = $bits(cbd_pkg::result_t);

  // front -> classified queue
  logic             cq_push, cq_full, cq_empty, cq_pop;
  cbd_pkg::class_t  cq_wdata, cq_rdata;

  // parser -> result queue
  logic             rq_push, rq_full;
  cbd_pkg::result_t rq_wdata, rq_rdata;

  // Classify each accepted byte
  cbd_front u_front (
    .in_push (in_push),
    .in_byte (in_byte),
    .in_full (in_full),
    .q_full  (cq_full),
    .q_push  (cq_push),
    .q_data  (cq_wdata)
  );

  // Decouple the classifier from the parser
  cbd_fifo #(
    .WIDTH (CW),
    .DEPTH (QUEUE_DEPTH)
  ) u_class_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cq_push),
    .push_data (cq_wdata),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_data  (cq_rdata),
    .empty     (cq_empty)
  );

  // Run the chunk state machine; advance only when a result slot is free
  cbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (cq_empty),
    .q_data   (cq_rdata),
    .q_pop    (cq_pop),
    .res_full (rq_full),
    .res_push (rq_push),
    .res_data (rq_wdata)
  );

  // Hold results until the consumer pops them
  cbd_fifo #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rq_push),
    .push_data (rq_wdata),
    .full      (rq_full),
    .pop       (out_pop),
    .pop_data  (rq_rdata),
    .empty     (out_empty)
  );

  assign out_data_valid      = rq_rdata.data_valid;
  assign out_data_byte       = rq_rdata.data_byte;
  assign out_chunk_last_byte = rq_rdata.chunk_last_byte;
  assign out_status          = rq_rdata.status;

endmodule

### src/cbd_fifo.sv
// Small first-word-fall-through queue in flops. DEPTH must be 2 or more.
module cbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/cbd_front.sv
// Accept raw bytes and classify them for the parser.
module cbd_front (
  input  logic            in_push,
  input  logic [7:0]      in_byte,
  output logic            in_full,
  input  logic            q_full,
  output logic            q_push,
  output cbd_pkg::class_t q_data
);

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_data         = '0;
    q_data.raw     = in_byte;
    q_data.is_cr   = (in_byte == cbd_pkg::CH_CR);
    q_data.is_lf   = (in_byte == cbd_pkg::CH_LF);
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      q_data.is_hex  = 1'b1;
      q_data.hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      // letters a..f share low bits 1..6 in both cases
      q_data.is_hex  = 1'b1;
      q_data.hex_val = 4'(in_byte[2:0] + 4'd9);
    end
  end

endmodule

### src/cbd_back.sv
// Chunk parser: consume classified words, produce one result word each.
module cbd_back #(
  parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  cbd_pkg::class_t  q_data,
  output logic             q_pop,
  input  logic             res_full,
  output logic             res_push,
  output cbd_pkg::result_t res_data
);

  localparam int DB = cbd_pkg::HEX_DIGIT_BITS;

  cbd_pkg::phase_t phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] remaining_r, remaining_nxt;
  logic                 seen_r, seen_nxt;
  logic                 last_r, last_nxt;
  logic                 fire;
  logic                 overflow;
  logic                 rem_one;

  assign fire     = !q_empty && !res_full;
  assign q_pop    = fire;
  assign res_push = fire;
  assign overflow = (remaining_r[SIZE_BITS-1 -: DB] != '0);
  assign rem_one  = (remaining_r == SIZE_BITS'(1));

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    seen_nxt      = seen_r;
    last_nxt      = last_r;
    if (fire) begin
      case (phase_r)
        cbd_pkg::PH_SIZE: begin
          if (q_data.is_cr) begin
            phase_nxt = seen_r ? cbd_pkg::PH_SIZE_LF : cbd_pkg::PH_ERROR;
          end else if (!q_data.is_hex || overflow) begin
            phase_nxt = cbd_pkg::PH_ERROR;
          end else begin
            remaining_nxt = {remaining_r[SIZE_BITS-DB-1:0], q_data.hex_val};
            seen_nxt      = 1'b1;
          end
        end
        cbd_pkg::PH_SIZE_LF: begin
          if (!q_data.is_lf) begin
            phase_nxt = cbd_pkg::PH_ERROR;
          end else if (remaining_r == '0) begin
            last_nxt  = 1'b1;
            phase_nxt = cbd_pkg::PH_DATA_CR;
          end else begin
            phase_nxt = cbd_pkg::PH_DATA;
          end
        end
        cbd_pkg::PH_DATA: begin
          remaining_nxt = remaining_r - 1'b1;
          if (rem_one) begin
            phase_nxt = cbd_pkg::PH_DATA_CR;
          end
        end
        cbd_pkg::PH_DATA_CR: begin
          phase_nxt = q_data.is_cr ? cbd_pkg::PH_DATA_LF : cbd_pkg::PH_ERROR;
        end
        cbd_pkg::PH_DATA_LF: begin
          if (!q_data.is_lf) begin
            phase_nxt = cbd_pkg::PH_ERROR;
          end else if (last_r) begin
            phase_nxt = cbd_pkg::PH_DONE;
          end else begin
            phase_nxt     = cbd_pkg::PH_SIZE;
            remaining_nxt = '0;
            seen_nxt      = 1'b0;
          end
        end
        default: begin
          phase_nxt = cbd_pkg::PH_ERROR;
        end
      endcase
    end
  end

  // Result word
  always_comb begin
    res_data = '0;
    if (phase_r == cbd_pkg::PH_DATA) begin
      res_data.data_valid      = 1'b1;
      res_data.data_byte       = q_data.raw;
      res_data.chunk_last_byte = rem_one;
    end
    case (phase_nxt)
      cbd_pkg::PH_DONE:  res_data.status = cbd_pkg::STATUS_DONE;
      cbd_pkg::PH_ERROR: res_data.status = cbd_pkg::STATUS_ERROR;
      default:           res_data.status = cbd_pkg::STATUS_BUSY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cbd_pkg::PH_SIZE;
      remaining_r <= '0;
      seen_r      <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      seen_r      <= seen_nxt;
      last_r      <= last_nxt;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cbd_pkg::PH_ERROR |=> phase_r == cbd_pkg::PH_ERROR)
    else $error("error phase left before reset");

  a_data_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cbd_pkg::PH_DATA |-> remaining_r != '0)
    else $error("payload phase with zero bytes left");

  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_data.chunk_last_byte |-> res_data.data_valid)
    else $error("chunk end flagged on a non-payload word");

  a_chunk_end_to_cr: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_data.chunk_last_byte |=> phase_r == cbd_pkg::PH_DATA_CR)
    else $error("chunk end not followed by CR wait");

endmodule
